### src/barometric_altitude_and_climb_rate_core_macros.svh
// Assertion macros shared by the barometric altitude core.
`ifndef BAROMETRIC_ALTITUDE_AND_CLIMB_RATE_CORE_MACROS_SVH
`define BAROMETRIC_ALTITUDE_AND_CLIMB_RATE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BACR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BACR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/bacr_pkg.sv
// Shared widths, constants and the square-root table of the barometric altitude core.
package bacr_pkg;

	localparam int unsigned TEMP_W  = 15;
	localparam int unsigned PRESS_W = 25;
	localparam int unsigned ALT_W   = 27;
	localparam int unsigned CLIMB_W = 28;
	localparam int unsigned BASEP_W = 17;
	localparam int unsigned HB_W    = 26;
	localparam int unsigned LAPSE_W = 16;
	localparam int unsigned EXPN_W  = 20;
	localparam int unsigned CT_W    = 16;
	localparam int unsigned CFG_W   = 26;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned MANT_W = 31;
	localparam int unsigned FRAC_W = 32;
	localparam int unsigned LOG_W  = 37;
	localparam int unsigned SHIFT_W = 7;
	localparam int unsigned M22_W  = 29;
	localparam int unsigned ROOT_N = 32;
	localparam int unsigned ROOT_IDX_W = 5;

	localparam logic [M22_W-1:0] M22_ONE = 29'h0040_0000;
	localparam logic [M22_W-1:0] M22_LIM = 29'h1040_0000;

	localparam int ALT_MIN   = -2000000;
	localparam int ALT_MAX   = 50000000;
	localparam int CLIMB_MAX = 100000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_PRESSURE = 3'd0,
		CFG_BASE_ALTITUDE = 3'd1,
		CFG_LAPSE_RATE    = 3'd2,
		CFG_POWER_EXP     = 3'd3,
		CFG_CYCLE_TIME    = 3'd4
	} cfg_reg_t;

	typedef logic [MANT_W-1:0] root_tab_t [ROOT_N];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		int i;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		v = x;
		for (i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Entry k holds 2^(2^-(k+1)) in Q30, each taken as the root of the one before.
	function automatic root_tab_t build_roots();
		root_tab_t tab;
		logic [63:0] c;
		int k;
		c = 64'd1 << 31;
		for (k = 0; k < ROOT_N; k++) begin
			c = isqrt64(c << 30);
			tab[k] = c[MANT_W-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP2_ROOTS = build_roots();

endpackage

### src/bacr_log2.sv
// Bit-serial log2 unit: normalizes one bit per cycle, then squares once per fraction bit.
module bacr_log2 #(
	parameter int unsigned ITER = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [bacr_pkg::PRESS_W-1:0] x,
	output logic busy,
	output logic [bacr_pkg::LOG_W-1:0] log_val
);
	import bacr_pkg::*;

	localparam int unsigned CW  = $clog2(ITER);
	localparam int unsigned FSH = FRAC_W - ITER;

	typedef enum logic [2:0] {
		LG_IDLE = 3'b001,
		LG_NORM = 3'b010,
		LG_ITER = 3'b100
	} lg_state_t;

	lg_state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [MANT_W-1:0] mant_q;
	logic [4:0] p_q;
	logic [FRAC_W-1:0] f_q;
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0] sq_hi;

	assign sq = mant_q * mant_q;
	assign sq_hi = sq[2*MANT_W-1:MANT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				LG_IDLE: begin
					if (start) begin
						state_q <= LG_NORM;
					end
					cnt_q <= '0;
				end
				LG_NORM: begin
					if (mant_q[MANT_W-1]) begin
						state_q <= LG_ITER;
					end
				end
				LG_ITER: begin
					if (cnt_q == CW'(ITER - 1)) begin
						state_q <= LG_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				default: state_q <= LG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == LG_IDLE && start) begin
			mant_q <= {x, 6'b0};
			p_q <= 5'd24;
			f_q <= '0;
		end else if (state_q == LG_NORM && !mant_q[MANT_W-1]) begin
			mant_q <= {mant_q[MANT_W-2:0], 1'b0};
			p_q <= p_q - 1'b1;
		end else if (state_q == LG_ITER) begin
			// A square of two or more halves the mantissa and yields a one bit.
			mant_q <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
			f_q <= {f_q[FRAC_W-2:0], sq_hi[MANT_W]};
		end
	end

	assign busy = (state_q != LG_IDLE);
	assign log_val = {p_q, FRAC_W'(f_q << FSH)};

endmodule

### src/bacr_exp2.sv
// Serial exp2 unit: one root product per fraction bit, then a one-bit-per-cycle scale by 2^n.
module bacr_exp2 #(
	parameter int unsigned ITER = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [bacr_pkg::FRAC_W-1:0] frac,
	input  logic signed [bacr_pkg::SHIFT_W-1:0] shift_amt,
	output logic busy,
	output logic [bacr_pkg::M22_W-1:0] m22
);
	import bacr_pkg::*;

	localparam int unsigned CW = $clog2(ITER);
	localparam int unsigned MV_W = 62;

	typedef enum logic [2:0] {
		EX_IDLE  = 3'b001,
		EX_ITER  = 3'b010,
		EX_SHIFT = 3'b100
	} ex_state_t;

	ex_state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [SHIFT_W-2:0] amt_q;
	logic left_q;
	logic [FRAC_W-1:0] f_q;
	logic [MV_W-1:0] mv_q;
	logic [2*MANT_W-1:0] prod;
	logic [MV_W-9:0] scaled;

	assign prod = mv_q[MANT_W-1:0] * EXP2_ROOTS[ROOT_IDX_W'(cnt_q)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			cnt_q <= '0;
			amt_q <= '0;
		end else begin
			unique case (state_q)
				EX_IDLE: begin
					if (start) begin
						state_q <= EX_ITER;
						amt_q <= shift_amt[SHIFT_W-1] ? (SHIFT_W-1)'(-shift_amt)
							: shift_amt[SHIFT_W-2:0];
					end
					cnt_q <= '0;
				end
				EX_ITER: begin
					if (cnt_q == CW'(ITER - 1)) begin
						state_q <= EX_SHIFT;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				EX_SHIFT: begin
					if (amt_q == '0) begin
						state_q <= EX_IDLE;
					end else begin
						amt_q <= amt_q - 1'b1;
					end
				end
				default: state_q <= EX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EX_IDLE && start) begin
			mv_q <= MV_W'(1) << 30;
			f_q <= frac;
			left_q <= !shift_amt[SHIFT_W-1];
		end else if (state_q == EX_ITER) begin
			if (f_q[FRAC_W-1]) begin
				mv_q <= MV_W'(prod[2*MANT_W-2:MANT_W-1]);
			end
			f_q <= {f_q[FRAC_W-2:0], 1'b0};
		end else if (state_q == EX_SHIFT && amt_q != '0) begin
			mv_q <= left_q ? {mv_q[MV_W-2:0], 1'b0} : {1'b0, mv_q[MV_W-1:1]};
		end
	end

	assign scaled = mv_q[MV_W-1:8];
	assign m22 = (scaled > (MV_W-8)'(M22_LIM)) ? M22_LIM : scaled[M22_W-1:0];
	assign busy = (state_q != EX_IDLE);

endmodule

### src/bacr_smul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module bacr_smul #(
	parameter int unsigned AW = 38,
	parameter int unsigned BW = 29
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic busy,
	output logic [AW+BW-1:0] prod
);
	localparam int unsigned CW = $clog2(BW);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [AW-1:0] hi_q;
	logic [BW-1:0] lo_q;
	logic [AW:0] sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (!busy_q) begin
			busy_q <= start;
			cnt_q <= '0;
		end else begin
			if (cnt_q == CW'(BW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q, lo_q};

endmodule

### src/bacr_sdiv.sv
// Restoring divider that produces one quotient bit per cycle.
module bacr_sdiv #(
	parameter int unsigned NW = 47,
	parameter int unsigned DW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (!busy_q) begin
			busy_q <= start;
			cnt_q <= '0;
		end else begin
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

### src/barometric_altitude_and_climb_rate_core.sv
// Top level of the barometric altitude and climb rate core.
// One sample enters on the s_ channel: temperature in 0.01 degC and pressure in
// Pa (Q17.8). One result leaves on the m_ channel: altitude in mm, climb rate in
// mm/s, and in m_tuser a flag that marks a held altitude (zero pressure, zero
// lapse rate or zero base pressure). Registers are written on the cfg_ channel,
// which is always ready; write them only while no sample is in flight.
// A sample is worked by shared serial units: two log2 units (normalize, then
// one squaring per fraction bit), a shift-and-add multiplier (used twice), an
// exp2 unit and a restoring divider (used twice). How long a valid sample takes
// depends on the normalizing shifts and on the scale by the integer power; a
// flagged sample skips the serial units. One sample is worked at a time; the
// next is accepted as soon as the result is written to the output register,
// even while that result still waits for m_tready.
// When the receiver stalls, the finished result waits and the core holds.
// Reset restores the register defaults and clears the stored altitude.
`include "barometric_altitude_and_climb_rate_core_macros.svh"

module barometric_altitude_and_climb_rate_core #(
	parameter int unsigned EXP_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata, // temperature_centi_c [14:0], pressure_pa_q8 [39:15]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [55:0] m_tdata, // altitude_mm [26:0], climb_rate_mm_s [54:27], zero [55]
	output logic [0:0] m_tuser,  // invalid_flag [0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bacr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bacr_pkg::CFG_W-1:0] cfg_data
);
	import bacr_pkg::*;

	localparam int unsigned MUL_AW = 38;
	localparam int unsigned MUL_BW = 29;
	localparam int unsigned DIV_NW = 47;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOG  = 9'b000000010,
		ST_MULY = 9'b000000100,
		ST_EXPO = 9'b000001000,
		ST_MULN = 9'b000010000,
		ST_DIVA = 9'b000100000,
		ST_CLMB = 9'b001000000,
		ST_DIVC = 9'b010000000,
		ST_FIN  = 9'b100000000
	} st_t;

	st_t state_q, state_d;

	logic [BASEP_W-1:0] base_p_q;
	logic signed [HB_W-1:0] hb_q;
	logic signed [LAPSE_W-1:0] lapse_q;
	logic [EXPN_W-1:0] expn_q;
	logic [CT_W-1:0] ct_q;
	logic [CT_W-1:0] ct_eff;
	logic [LAPSE_W-1:0] lapse_mag;

	logic signed [TEMP_W-1:0] in_temp;
	logic [PRESS_W-1:0] in_press;
	logic in_invalid;
	logic accept;
	logic signed [16:0] tck;
	logic [32:0] k_in;
	logic [32:0] k_q;

	logic lp_busy, lb_busy, mul_busy, exp_busy, div_busy;
	logic log_start, mul_start, exp_start, div_start;
	logic [LOG_W-1:0] lp_val, lb_val;
	logic signed [LOG_W+1:0] logr;
	logic [LOG_W:0] logr_mag;
	logic logneg_q;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_AW+MUL_BW-1:0] mul_prod;
	logic [58:0] ynn;
	logic signed [SHIFT_W-1:0] exp_shift;
	logic [M22_W-1:0] exp_m22;
	logic signed [M22_W:0] d22;
	logic [M22_W-1:0] d22_mag;
	logic dneg_q;
	logic [DIV_NW-1:0] div_num;
	logic [CT_W-1:0] div_den;
	logic [DIV_NW-1:0] div_quo;

	logic signed [48:0] q49;
	logic signed [48:0] alt_sum;
	logic signed [ALT_W-1:0] alt_clamped;
	logic signed [CLIMB_W-1:0] diff;
	logic [CLIMB_W-1:0] diff_mag;
	logic [37:0] climb_num;
	logic cneg_q;
	logic [26:0] climb_mag;

	logic signed [ALT_W-1:0] alt_q;
	logic signed [CLIMB_W-1:0] climb_q;
	logic inv_q;
	logic signed [ALT_W-1:0] prev_q;
	logic signed [ALT_W-1:0] out_alt_q;
	logic signed [CLIMB_W-1:0] out_climb_q;
	logic out_inv_q;
	logic m_tvalid_q;
	logic out_free;
	logic [3:0] units_busy;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_p_q <= 17'd101325;
			hb_q <= '0;
			lapse_q <= -16'sd6500;
			expn_q <= 20'd199506;
			ct_q <= 16'd100;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BASE_PRESSURE: base_p_q <= cfg_data[BASEP_W-1:0];
				CFG_BASE_ALTITUDE: hb_q <= cfg_data[HB_W-1:0];
				CFG_LAPSE_RATE:    lapse_q <= cfg_data[LAPSE_W-1:0];
				CFG_POWER_EXP:     expn_q <= cfg_data[EXPN_W-1:0];
				CFG_CYCLE_TIME:    ct_q <= cfg_data[CT_W-1:0];
				default: ;
			endcase
		end
	end

	assign ct_eff = (ct_q == '0) ? CT_W'(1) : ct_q;
	assign lapse_mag = lapse_q[LAPSE_W-1] ? LAPSE_W'(-lapse_q) : lapse_q;

	// Input side.
	assign in_temp = s_tdata[TEMP_W-1:0];
	assign in_press = s_tdata[TEMP_W+PRESS_W-1:TEMP_W];
	assign in_invalid = (in_press == '0) || (lapse_q == '0) || (base_p_q == '0);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign tck = 17'(in_temp) + 17'sd27315;
	assign k_in = 33'(tck[15:0]) * 33'd78125;

	// Arithmetic between the serial units.
	assign logr = $signed({2'b0, lp_val}) - $signed({2'b0, lb_val})
		- $signed(39'h8_0000_0000);
	assign logr_mag = logr[LOG_W+1] ? (LOG_W+1)'(-logr) : logr[LOG_W:0];

	assign ynn = logneg_q ? ((59'd1 << 57) - 59'(mul_prod[57:0]))
		: ((59'd1 << 57) + 59'(mul_prod[57:0]));
	assign exp_shift = $signed({1'b0, ynn[57:52]}) - 7'sd32;

	assign d22 = $signed({1'b0, exp_m22}) - $signed({1'b0, M22_ONE});
	assign d22_mag = d22[M22_W] ? M22_W'(-d22) : d22[M22_W-1:0];

	assign q49 = $signed({2'b0, div_quo});
	assign alt_sum = (dneg_q ^ lapse_q[LAPSE_W-1]) ? (49'(hb_q) - q49) : (49'(hb_q) + q49);
	always_comb begin
		if (alt_sum < 49'(ALT_MIN)) begin
			alt_clamped = ALT_W'(ALT_MIN);
		end else if (alt_sum > 49'(ALT_MAX)) begin
			alt_clamped = ALT_W'(ALT_MAX);
		end else begin
			alt_clamped = alt_sum[ALT_W-1:0];
		end
	end

	assign diff = CLIMB_W'(alt_q) - CLIMB_W'(prev_q);
	assign diff_mag = diff[CLIMB_W-1] ? CLIMB_W'(-diff) : diff;
	assign climb_num = 38'(diff_mag) * 38'd1000;
	assign climb_mag = (div_quo > DIV_NW'(CLIMB_MAX)) ? 27'(CLIMB_MAX) : div_quo[26:0];

	// Unit starts and operand selection.
	assign log_start = accept && !in_invalid;
	assign mul_start = ((state_q == ST_LOG) && !lp_busy && !lb_busy)
		|| ((state_q == ST_EXPO) && !exp_busy);
	assign exp_start = (state_q == ST_MULY) && !mul_busy;
	assign div_start = ((state_q == ST_MULN) && !mul_busy) || (state_q == ST_CLMB);

	assign mul_a = (state_q == ST_LOG) ? logr_mag : MUL_AW'(k_q);
	assign mul_b = (state_q == ST_LOG) ? MUL_BW'(expn_q) : d22_mag;
	assign div_num = (state_q == ST_MULN) ? mul_prod[61:15] : DIV_NW'(climb_num);
	assign div_den = (state_q == ST_MULN) ? lapse_mag : ct_eff;

	bacr_log2 #(.ITER(EXP_ITERATIONS)) u_log_press (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(in_press),
		.busy(lp_busy), .log_val(lp_val)
	);

	bacr_log2 #(.ITER(EXP_ITERATIONS)) u_log_base (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(PRESS_W'(base_p_q)),
		.busy(lb_busy), .log_val(lb_val)
	);

	bacr_smul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .prod(mul_prod)
	);

	bacr_exp2 #(.ITER(EXP_ITERATIONS)) u_exp (
		.clk(clk), .arst_n(arst_n), .start(exp_start), .frac(ynn[51:20]),
		.shift_amt(exp_shift), .busy(exp_busy), .m22(exp_m22)
	);

	bacr_sdiv #(.NW(DIV_NW), .DW(CT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo)
	);

	// Sequencer.
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = in_invalid ? ST_FIN : ST_LOG;
			ST_LOG:  if (!lp_busy && !lb_busy) state_d = ST_MULY;
			ST_MULY: if (!mul_busy) state_d = ST_EXPO;
			ST_EXPO: if (!exp_busy) state_d = ST_MULN;
			ST_MULN: if (!mul_busy) state_d = ST_DIVA;
			ST_DIVA: if (!div_busy) state_d = ST_CLMB;
			ST_CLMB: state_d = ST_DIVC;
			ST_DIVC: if (!div_busy) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			prev_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
				if (!inv_q) begin
					prev_q <= alt_q;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k_q <= k_in;
			inv_q <= in_invalid;
			if (in_invalid) begin
				alt_q <= prev_q;
				climb_q <= '0;
			end
		end
		if (state_q == ST_LOG) begin
			logneg_q <= logr[LOG_W+1];
		end
		if (state_q == ST_EXPO) begin
			dneg_q <= d22[M22_W];
		end
		if (state_q == ST_DIVA && !div_busy) begin
			alt_q <= alt_clamped;
		end
		if (state_q == ST_CLMB) begin
			cneg_q <= diff[CLIMB_W-1];
		end
		if (state_q == ST_DIVC && !div_busy) begin
			climb_q <= cneg_q ? -CLIMB_W'(climb_mag) : CLIMB_W'(climb_mag);
		end
		if (state_q == ST_FIN && out_free) begin
			out_alt_q <= alt_q;
			out_climb_q <= climb_q;
			out_inv_q <= inv_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {1'b0, out_climb_q, out_alt_q};
	assign m_tuser = out_inv_q;

	assign units_busy = {mul_busy, div_busy, exp_busy, lp_busy | lb_busy};

	`BACR_ASSERT_NOW(a_held_climb_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[54:27] == '0, "flagged result has nonzero climb rate")
	`BACR_ASSERT_NOW(a_alt_in_range, clk, arst_n, m_tvalid, (out_alt_q >= ALT_W'(ALT_MIN)) && (out_alt_q <= ALT_W'(ALT_MAX)), "altitude outside its range")
	`BACR_ASSERT_NOW(a_one_unit_busy, clk, arst_n, 1'b1, $countones(units_busy) <= 1, "two serial units busy at once")
	`BACR_ASSERT_NEXT(a_accept_blocks, clk, arst_n, s_tvalid && s_tready, !s_tready, "second transaction accepted while busy")

endmodule

### bench/bacr_checker.sv
// Checker for the barometric altitude core: watches the channels, predicts and compares.
module bacr_checker #(
	parameter int unsigned EXP_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [39:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [55:0] m_tdata,
	input  logic [0:0] m_tuser,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [bacr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bacr_pkg::CFG_W-1:0] cfg_data,
	output int errors,
	output int pending,
	output int n_results,
	output int n_flagged
);
	timeunit 1ns;
	timeprecision 1ps;
	import bacr_pkg::*;

	typedef struct packed {
		logic [ALT_W-1:0] altitude;
		logic [CLIMB_W-1:0] climb;
		logic flag;
	} fix_t;

	fix_t expected_fixes[$];

	logic [BASEP_W-1:0] base_press;
	logic signed [HB_W-1:0] base_alt;
	logic signed [LAPSE_W-1:0] lapse;
	logic [EXPN_W-1:0] expo;
	logic [CT_W-1:0] period_ms;
	longint last_alt;
	longint unsigned halving_roots[32];

	assign pending = expected_fixes.size();

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	initial begin
		longint unsigned c;
		c = 64'd1 << 31;
		for (int k = 0; k < 32; k++) begin
			c = int_sqrt(c << 30);
			halving_roots[k] = c;
		end
	end

	// Integer part in the upper bits, EXP_ITERATIONS fraction bits from repeated squaring.
	function automatic longint unsigned log2_fixed(longint unsigned x);
		int p;
		longint unsigned mant, frac;
		p = 0;
		frac = 0;
		while ((x >> p) > 1)
			p++;
		mant = x << (30 - p);
		for (int i = 1; i <= EXP_ITERATIONS && i <= 32; i++) begin
			mant = (mant * mant) >> 30;
			if (mant >= (64'd1 << 31)) begin
				mant = mant >> 1;
				frac = frac | (64'd1 << (32 - i));
			end
		end
		return (longint'(p) << 32) | frac;
	endfunction

	function automatic longint unsigned exp2_fraction(longint unsigned f);
		longint unsigned m;
		m = 64'd1 << 30;
		for (int k = 1; k <= EXP_ITERATIONS && k <= 32; k++)
			if ((f >> (32 - k)) & 1)
				m = (m * halving_roots[k-1]) >> 30;
		return m;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic fix_t altitude_fix(logic signed [TEMP_W-1:0] temp,
			logic [PRESS_W-1:0] press);
		fix_t f;
		longint alt, climb, logr, y52, d22, num, den, tck;
		longint unsigned ynn, m, m22, ct;
		int n;
		ct = (period_ms == 0) ? 1 : longint'(period_ms);
		f.flag = (press == 0) || (lapse == 0) || (base_press == 0);
		if (f.flag) begin
			alt = last_alt;
			climb = 0;
		end else begin
			tck = longint'(temp) + 27315;
			logr = longint'(log2_fixed(press)) - longint'(log2_fixed(base_press))
				- (longint'(8) << 32);
			y52 = logr * longint'(expo);
			ynn = y52 + (longint'(1) << 57);
			n = int'(ynn >> 52) - 32;
			m = exp2_fraction((ynn >> 20) & 64'hFFFF_FFFF);
			m = (n >= 0) ? (m << n) : (m >> (-n));
			m22 = m >> 8;
			if (m22 > (64'd1 << 28) + (64'd1 << 22))
				m22 = (64'd1 << 28) + (64'd1 << 22);
			d22 = longint'(m22) - (longint'(1) << 22);
			num = d22 * tck * 78125;
			den = longint'(lapse) * 32768;
			alt = clip(num / den + longint'(base_alt), ALT_MIN, ALT_MAX);
			climb = clip((alt - last_alt) * 1000 / longint'(ct), -CLIMB_MAX, CLIMB_MAX);
			last_alt = alt;
		end
		f.altitude = alt[ALT_W-1:0];
		f.climb = climb[CLIMB_W-1:0];
		return f;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d, expected %0d", n_results, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fix_t want;
		if (!arst_n) begin
			base_press <= 101325;
			base_alt <= '0;
			lapse <= -16'sd6500;
			expo <= 199506;
			period_ms <= 100;
			last_alt = 0;
			expected_fixes.delete();
			errors = 0;
			n_results <= 0;
			n_flagged <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BASE_PRESSURE: base_press <= cfg_data[BASEP_W-1:0];
					CFG_BASE_ALTITUDE: base_alt <= cfg_data[HB_W-1:0];
					CFG_LAPSE_RATE: lapse <= cfg_data[LAPSE_W-1:0];
					CFG_POWER_EXP: expo <= cfg_data[EXPN_W-1:0];
					CFG_CYCLE_TIME: period_ms <= cfg_data[CT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_fixes.push_back(altitude_fix(s_tdata[14:0], s_tdata[39:15]));
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (m_tuser[0])
					n_flagged <= n_flagged + 1;
				if (expected_fixes.size() == 0) begin
					$display("unexpected transaction on the result channel");
					errors++;
				end else begin
					want = expected_fixes.pop_front();
					if (m_tdata[26:0] != want.altitude)
						report("altitude", $signed(m_tdata[26:0]), $signed(want.altitude));
					if (m_tdata[54:27] != want.climb)
						report("climb rate", $signed(m_tdata[54:27]), $signed(want.climb));
					if (m_tuser[0] != want.flag)
						report("invalid flag", m_tuser[0], want.flag);
				end
			end
		end
	end
endmodule

### bench/tb.sv
// Testbench top: drives samples and register writes into the altitude core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bacr_pkg::*;

	localparam int LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [55:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int errors, pending, n_results, n_flagged;
	int cycles;
	int out_stall;
	int n_sent;

	barometric_altitude_and_climb_rate_core dut (.*);
	bacr_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: draws a stall length after every transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall = 0;
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// s_tvalid is left high after a transaction; the next call or drain decides.
	task automatic send_sample(logic signed [TEMP_W-1:0] t, logic [PRESS_W-1:0] p);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p, t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_config(int bp, int hb, int lr, int ex, int ct);
		write_reg(CFG_BASE_PRESSURE, bp);
		write_reg(CFG_BASE_ALTITUDE, hb);
		write_reg(CFG_LAPSE_RATE, lr);
		write_reg(CFG_POWER_EXP, ex);
		write_reg(CFG_CYCLE_TIME, ct);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_sample();
		int pick;
		logic signed [TEMP_W-1:0] t;
		logic [PRESS_W-1:0] p;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			t = $urandom;
			p = $urandom;
		end else if (pick < 13) begin
			t = $urandom_range(0, 12500) - 4000;
			p = '0;
		end else begin
			t = $urandom_range(0, 12500) - 4000;
			p = ($urandom_range(30000, 110000) << 8) | $urandom_range(0, 255);
		end
		send_sample(t, p);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: field extremes, zero and full-scale pressure.
		send_sample(-4000, 101325 << 8);
		send_sample(8500, 90000 << 8);
		send_sample(-16384, 1);
		send_sample(16383, 25'h1FFFFFF);
		send_sample(0, 0);
		send_sample(2000, 80000 << 8);
		send_sample(2000, 101325 << 8);
		drain();

		load_config(131071, 20000000, 20000, 1048575, 65535);
		send_sample(1500, 131071 << 8);
		send_sample(-4000, 25'h1FFFFFF);
		send_sample(8500, 1);
		drain();

		load_config(1, -1000000, -20000, 0, 1);
		send_sample(1500, 256);
		send_sample(1500, 25'h1FFFFFF);
		send_sample(-16384, 5000 << 8);
		drain();

		// Zero lapse rate, zero base pressure, zero period, ignored indexes.
		load_config(101325, 0, 0, 199506, 0);
		send_sample(1500, 95000 << 8);
		drain();
		load_config(0, 0, -6500, 199506, 0);
		send_sample(1500, 95000 << 8);
		drain();
		load_config(101325, 12345, -6500, 199506, 0);
		write_reg(3'd5, 26'h3FFFFFF);
		write_reg(3'd6, 26'h1555555);
		write_reg(3'd7, 26'h2AAAAAA);
		cfg_valid <= 1'b0;
		send_sample(1500, 95000 << 8);
		send_sample(1600, 94000 << 8);
		send_sample(1600, 25'h1FFFFFF);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				load_config(101325, 0, -6500, 199506, 100);
			else if ($urandom_range(0, 3) == 0)
				load_config($urandom, $urandom, $urandom, $urandom, $urandom);
			else
				load_config($urandom_range(80000, 110000),
					$urandom_range(0, 21000000) - 1000000,
					$urandom_range(0, 40000) - 20000,
					$urandom_range(0, 1048575), $urandom_range(1, 65535));
			for (int i = 0; i < 50; i++)
				random_sample();
			drain();
		end

		$display("sent %0d samples over default, extreme and random register settings;",
			n_sent);
		$display("checked %0d results, %0d of them flagged invalid.", n_results, n_flagged);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
